>>> rtl/presence_tracker_exit_debounce_core_assert.svh
// assertion macros used by the checker module ptedb_chk
// depends on clk and rst_n being visible where a macro is used
`ifndef PRESENCE_TRACKER_EXIT_DEBOUNCE_CORE_ASSERT_SVH
`define PRESENCE_TRACKER_EXIT_DEBOUNCE_CORE_ASSERT_SVH

// clocked check, off while reset is held
`define PTEDB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define PTEDB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/ptedb_pkg.sv
// shared types and codes for the presence tracker
// no dependencies
`timescale 1ns / 1ps

package ptedb_pkg;

    // item commands
    localparam logic [1:0] CMD_EXIT    = 2'd0;
    localparam logic [1:0] CMD_ENTRY   = 2'd1;
    localparam logic [1:0] CMD_REFRESH = 2'd2;
    localparam logic [1:0] CMD_TICK    = 2'd3;

    // result kinds
    localparam logic [2:0] KIND_ENTRY    = 3'd0;
    localparam logic [2:0] KIND_HANDOVER = 3'd1;
    localparam logic [2:0] KIND_EXIT     = 3'd2;
    localparam logic [2:0] KIND_TICK     = 3'd3;
    localparam logic [2:0] KIND_FULL     = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_EXIT_WINDOW = 2'd0;
    localparam logic [1:0] CFG_SILENCE_THR = 2'd1;
    localparam logic [1:0] CFG_TELEM_EN    = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic sweep;
        logic act;
        logic flush;
    } ctl_t;

    // one result item
    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] user_key;
        logic [7:0]  from_host;
        logic [7:0]  to_host;
        logic [31:0] observed_at;
        logic [15:0] sample_count;
        logic [31:0] silent_total;
    } result_t;

endpackage

>>> rtl/ptedb_ctrl.sv
// sequencer: accept, sweep every slot, act on the item, flush the last result
// depends on ptedb_pkg
`timescale 1ns / 1ps

module ptedb_ctrl #(
    parameter int TABLE_DEPTH = 16,
    parameter int SLOT_W      = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output ptedb_pkg::ctl_t     ctl,
    output logic [SLOT_W-1:0]   slot
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SWEEP = 2'd1;
    localparam logic [1:0] ST_ACT   = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TABLE_DEPTH - 1);

    logic [1:0]        state_reg, state_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    // next state and slot counter
    always_comb
    begin
        state_next = state_reg;
        slot_next  = slot_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                slot_next = '0;
                if (start)
                begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                if (slot_reg == SLOT_LAST)
                begin
                    state_next = ST_ACT;
                end
                else
                begin
                    slot_next = slot_reg + 1'b1;
                end
            end
            ST_ACT:   state_next = ST_FLUSH;
            ST_FLUSH: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            slot_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
        end
    end

    // commands to the datapath
    assign busy      = (state_reg != ST_IDLE);
    assign ctl.load  = (state_reg == ST_IDLE) && start;
    assign ctl.sweep = (state_reg == ST_SWEEP);
    assign ctl.act   = (state_reg == ST_ACT);
    assign ctl.flush = (state_reg == ST_FLUSH);
    assign slot      = slot_reg;

endmodule

>>> rtl/ptedb_dp.sv
// user table, configuration registers and result registers
// depends on ptedb_pkg
`timescale 1ns / 1ps

module ptedb_dp #(
    parameter int TABLE_DEPTH = 16,
    parameter int SLOT_W      = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ptedb_pkg::ctl_t      ctl,
    input  logic [SLOT_W-1:0]    slot,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic [1:0]           cmd,
    input  logic [31:0]          user_id,
    input  logic [7:0]           host_id,
    input  logic [15:0]          samples,
    input  logic [31:0]          first_seen,
    input  logic [31:0]          frame_time,
    input  logic [31:0]          now,
    output logic                 res_valid,
    output ptedb_pkg::result_t   res,
    output logic                 res_last
);

    localparam int TICK_W = $clog2(TABLE_DEPTH + 1);

    // configuration
    logic [31:0] exit_window_reg;
    logic [31:0] silence_thr_reg;
    logic        telem_en_reg;

    // table: valid bits with reset, payload without
    logic [TABLE_DEPTH-1:0] entry_valid_reg;
    logic [TABLE_DEPTH-1:0] hold_active_reg;
    logic [TABLE_DEPTH-1:0] silence_marked_reg;
    logic [31:0] entry_user_reg    [TABLE_DEPTH];
    logic [7:0]  entry_host_reg    [TABLE_DEPTH];
    logic [31:0] hold_deadline_reg [TABLE_DEPTH];
    logic [15:0] hold_samples_reg  [TABLE_DEPTH];
    logic [31:0] hold_first_reg    [TABLE_DEPTH];
    logic [31:0] last_seen_reg     [TABLE_DEPTH];
    logic [31:0] silent_count_reg;

    // captured item
    logic [1:0]  cmd_reg;
    logic [31:0] user_reg;
    logic [7:0]  host_reg;
    logic [15:0] smp_reg;
    logic [31:0] first_reg;
    logic [31:0] ftime_reg;
    logic [31:0] now_reg;

    // sweep findings
    logic              found_reg;
    logic [SLOT_W-1:0] found_slot_reg;
    logic              free_reg;
    logic [SLOT_W-1:0] free_slot_reg;
    logic [TICK_W-1:0] tick_add_reg;

    // held result and output registers
    logic                pend_valid_reg;
    ptedb_pkg::result_t  pend_reg;
    logic                out_valid_reg;
    logic                out_last_reg;
    ptedb_pkg::result_t  out_reg;

    // per-slot checks during the sweep
    logic        sw_valid, sw_expired, sw_live, sw_match, sw_silent;
    logic [31:0] sw_gap;
    always_comb
    begin
        sw_valid   = entry_valid_reg[slot];
        sw_expired = sw_valid && hold_active_reg[slot]
                     && (now_reg >= hold_deadline_reg[slot]);
        sw_live    = sw_valid && !sw_expired;
        sw_match   = sw_live && (entry_user_reg[slot] == user_reg);
        sw_gap     = now_reg - last_seen_reg[slot];
        sw_silent  = (cmd_reg == ptedb_pkg::CMD_TICK) && telem_en_reg && sw_live
                     && !silence_marked_reg[slot]
                     && (now_reg >= last_seen_reg[slot]) && (sw_gap > silence_thr_reg);
    end

    // act step helpers
    logic [32:0] dl_sum;
    logic [31:0] dl_sat;
    logic [31:0] count_sum;
    logic [7:0]  fs_host;
    always_comb
    begin
        dl_sum    = {1'b0, now_reg} + {1'b0, exit_window_reg};
        dl_sat    = dl_sum[32] ? 32'hFFFF_FFFF : dl_sum[31:0];
        count_sum = silent_count_reg + 32'(tick_add_reg);
        fs_host   = entry_host_reg[found_slot_reg];
    end

    // result produced this cycle
    logic               new_valid;
    ptedb_pkg::result_t new_res;
    always_comb
    begin
        new_valid            = 1'b0;
        new_res              = '0;
        new_res.silent_total = silent_count_reg;
        new_res.user_key     = user_reg;
        new_res.to_host      = host_reg;
        new_res.observed_at  = first_reg;
        new_res.sample_count = smp_reg;
        if (ctl.sweep)
        begin
            new_valid            = sw_expired;
            new_res.kind         = ptedb_pkg::KIND_EXIT;
            new_res.user_key     = entry_user_reg[slot];
            new_res.from_host    = entry_host_reg[slot];
            new_res.to_host      = 8'd0;
            new_res.observed_at  = hold_first_reg[slot];
            new_res.sample_count = hold_samples_reg[slot];
        end
        else if (ctl.act)
        begin
            unique case (cmd_reg)
                ptedb_pkg::CMD_ENTRY:
                begin
                    if (!found_reg)
                    begin
                        new_valid    = 1'b1;
                        new_res.kind = free_reg ? ptedb_pkg::KIND_ENTRY
                                                : ptedb_pkg::KIND_FULL;
                    end
                    else if (fs_host != host_reg)
                    begin
                        new_valid         = 1'b1;
                        new_res.kind      = ptedb_pkg::KIND_HANDOVER;
                        new_res.from_host = fs_host;
                    end
                end
                ptedb_pkg::CMD_TICK:
                begin
                    new_valid    = 1'b1;
                    new_res      = '0;
                    new_res.kind = ptedb_pkg::KIND_TICK;
                    new_res.silent_total = count_sum;
                end
                default: new_valid = 1'b0;
            endcase
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exit_window_reg <= 32'd10000;
            silence_thr_reg <= 32'd60000;
            telem_en_reg    <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ptedb_pkg::CFG_EXIT_WINDOW: exit_window_reg <= cfg_data;
                ptedb_pkg::CFG_SILENCE_THR: silence_thr_reg <= cfg_data;
                ptedb_pkg::CFG_TELEM_EN:    telem_en_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // sweep findings, cleared when an item is loaded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg    <= 1'b0;
            free_reg     <= 1'b0;
            tick_add_reg <= '0;
        end
        else if (ctl.load)
        begin
            found_reg    <= 1'b0;
            free_reg     <= 1'b0;
            tick_add_reg <= '0;
        end
        else if (ctl.sweep)
        begin
            if (sw_match)
            begin
                found_reg <= 1'b1;
            end
            if (!sw_live && !free_reg)
            begin
                free_reg <= 1'b1;
            end
            if (sw_silent)
            begin
                tick_add_reg <= tick_add_reg + 1'b1;
            end
        end
    end

    // item payload and slot numbers
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg   <= cmd;
            user_reg  <= user_id;
            host_reg  <= host_id;
            smp_reg   <= samples;
            first_reg <= first_seen;
            ftime_reg <= frame_time;
            now_reg   <= now;
        end
        if (ctl.sweep && sw_match)
        begin
            found_slot_reg <= slot;
        end
        if (ctl.sweep && !sw_live && !free_reg)
        begin
            free_slot_reg <= slot;
        end
    end

    // table flags and silent count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg    <= '0;
            hold_active_reg    <= '0;
            silence_marked_reg <= '0;
            silent_count_reg   <= '0;
        end
        else if (ctl.sweep)
        begin
            if (sw_expired)
            begin
                entry_valid_reg[slot]    <= 1'b0;
                hold_active_reg[slot]    <= 1'b0;
                silence_marked_reg[slot] <= 1'b0;
            end
            if (sw_silent)
            begin
                silence_marked_reg[slot] <= 1'b1;
            end
        end
        else if (ctl.act)
        begin
            unique case (cmd_reg)
                ptedb_pkg::CMD_EXIT:
                begin
                    if (found_reg && fs_host == host_reg)
                    begin
                        hold_active_reg[found_slot_reg] <= 1'b1;
                    end
                end
                ptedb_pkg::CMD_ENTRY:
                begin
                    if (found_reg)
                    begin
                        hold_active_reg[found_slot_reg] <= 1'b0;
                    end
                    else if (free_reg)
                    begin
                        entry_valid_reg[free_slot_reg]    <= 1'b1;
                        hold_active_reg[free_slot_reg]    <= 1'b0;
                        silence_marked_reg[free_slot_reg] <= 1'b0;
                    end
                end
                ptedb_pkg::CMD_TICK: silent_count_reg <= count_sum;
                default: ;
            endcase
        end
    end

    // table payload
    always_ff @(posedge clk)
    begin
        if (ctl.act)
        begin
            unique case (cmd_reg)
                ptedb_pkg::CMD_EXIT:
                begin
                    if (found_reg && fs_host == host_reg)
                    begin
                        hold_deadline_reg[found_slot_reg] <= dl_sat;
                        hold_samples_reg[found_slot_reg]  <= smp_reg;
                        hold_first_reg[found_slot_reg]    <= first_reg;
                    end
                end
                ptedb_pkg::CMD_ENTRY:
                begin
                    if (found_reg)
                    begin
                        hold_samples_reg[found_slot_reg] <= 16'd0;
                        last_seen_reg[found_slot_reg]    <= now_reg;
                        entry_host_reg[found_slot_reg]   <= host_reg;
                    end
                    else if (free_reg)
                    begin
                        entry_user_reg[free_slot_reg]   <= user_reg;
                        entry_host_reg[free_slot_reg]   <= host_reg;
                        hold_samples_reg[free_slot_reg] <= 16'd0;
                        last_seen_reg[free_slot_reg]    <= now_reg;
                    end
                end
                ptedb_pkg::CMD_REFRESH:
                begin
                    if (found_reg && ftime_reg >= last_seen_reg[found_slot_reg])
                    begin
                        last_seen_reg[found_slot_reg] <= ftime_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    // one result held back so the final one can carry last
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            if (ctl.flush)
            begin
                out_valid_reg  <= pend_valid_reg;
                out_last_reg   <= pend_valid_reg;
                pend_valid_reg <= 1'b0;
            end
            else if (new_valid)
            begin
                out_valid_reg  <= pend_valid_reg;
                pend_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.flush || new_valid)
        begin
            out_reg <= pend_reg;
        end
        if (new_valid && !ctl.flush)
        begin
            pend_reg <= new_res;
        end
    end

    assign res_valid = out_valid_reg;
    assign res_last  = out_last_reg;
    assign res       = out_reg;

endmodule

>>> rtl/presence_tracker_exit_debounce_core.sv
// Presence tracker with exit debounce.
// Items enter on start when busy is low; cmd selects exit, entry, refresh
// or tick, and the other input ports carry the item's fields.
// Each item sweeps the user table one slot per cycle, reporting and
// removing users whose exit hold has expired, then acts on the item and
// flushes its final result. busy is high through the sweep, act and flush
// steps, and no new item is taken until busy falls.
// Results appear on the output ports for one cycle each, marked by valid,
// with last high on the final result of an item; an item gives zero to
// TABLE_DEPTH + 1 results. The receiver cannot stall the block.
// Configuration must be written through cfg_we, cfg_index and cfg_data
// while busy is low; the block itself does not enforce this. Reset clears
// the table, the silent count and the configuration to its defaults;
// the block is ready at once.
// depends on ptedb_pkg, ptedb_ctrl, ptedb_dp
`timescale 1ns / 1ps

module presence_tracker_exit_debounce_core #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic [1:0]  cmd,
    input  logic [31:0] user_id,
    input  logic [7:0]  host_id,
    input  logic [15:0] samples,
    input  logic [31:0] first_seen,
    input  logic [31:0] frame_time,
    input  logic [31:0] now,
    output logic        valid,
    output logic [2:0]  kind,
    output logic [31:0] user_key,
    output logic [7:0]  from_host,
    output logic [7:0]  to_host,
    output logic [31:0] observed_at,
    output logic [15:0] sample_count,
    output logic [31:0] silent_total,
    output logic        last
);

    localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    ptedb_pkg::ctl_t    ctl;
    logic [SLOT_W-1:0]  slot;
    ptedb_pkg::result_t res;

    // sequencer
    ptedb_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .SLOT_W      (SLOT_W)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .ctl   (ctl),
        .slot  (slot)
    );

    // table and results
    ptedb_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .SLOT_W      (SLOT_W)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .slot       (slot),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .user_id    (user_id),
        .host_id    (host_id),
        .samples    (samples),
        .first_seen (first_seen),
        .frame_time (frame_time),
        .now        (now),
        .res_valid  (valid),
        .res        (res),
        .res_last   (last)
    );

    assign kind         = res.kind;
    assign user_key     = res.user_key;
    assign from_host    = res.from_host;
    assign to_host      = res.to_host;
    assign observed_at  = res.observed_at;
    assign sample_count = res.sample_count;
    assign silent_total = res.silent_total;

endmodule

>>> rtl/ptedb_chk.sv
// port-level checks for the presence tracker, bound to the top level
// depends on ptedb_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "presence_tracker_exit_debounce_core_assert.svh"

module ptedb_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        valid,
    input logic [2:0]  kind,
    input logic [7:0]  to_host,
    input logic        last
);

    // an accepted item makes the block busy
    `PTEDB_ASSERT(a_start_busy, start && !busy |=> busy, "item accepted but not busy")

    // nothing follows the last result of an item in the next cycle
    `PTEDB_ASSERT(a_last_gap, valid && last |=> !valid, "result right after last")

    // tick status always closes its item
    `PTEDB_ASSERT(a_tick_last, valid && kind == ptedb_pkg::KIND_TICK |-> last, "tick not last")

    // a departure names no new host
    `PTEDB_ASSERT(a_exit_host, valid && kind == ptedb_pkg::KIND_EXIT |-> to_host == 8'd0, "exit to_host")

    // no result while reset is held
    `PTEDB_ASSERT_ALWAYS(a_rst_quiet, !rst_n |-> !valid, "result during reset")

endmodule

bind presence_tracker_exit_debounce_core ptedb_chk u_ptedb_chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .valid   (valid),
    .kind    (kind),
    .to_host (to_host),
    .last    (last)
);

>>> test/tb_presence_tracker_exit_debounce_core.sv
// testbench for the presence tracker with exit debounce: directed and random items,
// each result checked against an in-bench tracker; depends on ptedb_pkg and the core
`timescale 1ns / 1ps

module tb_presence_tracker_exit_debounce_core;

    localparam int DEPTH = 16;
    localparam int LIMIT = 400000;

    // one expected or observed result
    typedef struct {
        logic [2:0]  kind;
        logic [31:0] user_key;
        logic [7:0]  from_host;
        logic [7:0]  to_host;
        logic [31:0] observed_at;
        logic [15:0] sample_count;
        logic [31:0] silent_total;
        logic        last;
    } presence_rec_t;

    // tracker of expected departures, entries, handovers, full reports and tick reports
    class presence_board;
        bit [31:0] win, thr;
        bit        telem;
        bit        occ[DEPTH];
        bit [31:0] uid[DEPTH];
        bit [7:0]  hid[DEPTH];
        bit        held[DEPTH];
        bit [31:0] dl[DEPTH];
        bit [15:0] hsmp[DEPTH];
        bit [31:0] hfirst[DEPTH];
        bit [31:0] seen[DEPTH];
        bit        marked[DEPTH];
        bit [31:0] silent;
        presence_rec_t pending[$];
        int        errors;

        function void clear();
            win = 10000; thr = 60000; telem = 1; silent = 0;
            foreach (occ[i]) begin
                occ[i] = 0; held[i] = 0; marked[i] = 0;
            end
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] v);
            if (idx == ptedb_pkg::CFG_EXIT_WINDOW) win = v;
            else if (idx == ptedb_pkg::CFG_SILENCE_THR) thr = v;
            else if (idx == ptedb_pkg::CFG_TELEM_EN) telem = v[0];
        endfunction

        function void add_rec(logic [2:0] k, logic [31:0] u, logic [7:0] f, logic [7:0] t,
                              logic [31:0] o, logic [15:0] s, ref presence_rec_t acc[$]);
            presence_rec_t r;
            r.kind = k; r.user_key = u; r.from_host = f; r.to_host = t;
            r.observed_at = o; r.sample_count = s; r.silent_total = silent; r.last = 0;
            acc = {acc, r};
        endfunction

        // note an accepted item and queue the results it causes
        function void note_item(logic [1:0] c, logic [31:0] u, logic [7:0] h,
                                logic [15:0] smp, logic [31:0] fs, logic [31:0] ft,
                                logic [31:0] tnow);
            presence_rec_t acc[$];
            int s, f;
            bit [31:0] d;
            bit [7:0]  prev;
            s = -1; f = -1;
            for (int i = 0; i < DEPTH; i++)
                if (occ[i] && held[i] && tnow >= dl[i]) begin
                    add_rec(ptedb_pkg::KIND_EXIT, uid[i], hid[i], 8'h0, hfirst[i], hsmp[i],
                            acc);
                    occ[i] = 0; held[i] = 0; marked[i] = 0;
                end
            for (int i = DEPTH - 1; i >= 0; i--)
                if (occ[i] && uid[i] == u) s = i;
            case (c)
                ptedb_pkg::CMD_EXIT:
                    if (s >= 0 && hid[s] == h) begin
                        d = tnow + win;
                        if (d < tnow) d = 32'hffff_ffff;
                        held[s] = 1; dl[s] = d; hsmp[s] = smp; hfirst[s] = fs;
                    end
                ptedb_pkg::CMD_ENTRY:
                    if (s < 0) begin
                        for (int i = DEPTH - 1; i >= 0; i--)
                            if (!occ[i]) f = i;
                        if (f < 0) add_rec(ptedb_pkg::KIND_FULL, u, 8'h0, h, fs, smp, acc);
                        else begin
                            occ[f] = 1; uid[f] = u; hid[f] = h; held[f] = 0;
                            hsmp[f] = 0; seen[f] = tnow; marked[f] = 0;
                            add_rec(ptedb_pkg::KIND_ENTRY, u, 8'h0, h, fs, smp, acc);
                        end
                    end else begin
                        prev = hid[s];
                        held[s] = 0; hsmp[s] = 0; seen[s] = tnow;
                        if (prev != h) begin
                            hid[s] = h;
                            add_rec(ptedb_pkg::KIND_HANDOVER, u, prev, h, fs, smp, acc);
                        end
                    end
                ptedb_pkg::CMD_REFRESH:
                    if (s >= 0 && ft >= seen[s]) seen[s] = ft;
                default: begin
                    if (telem)
                        for (int i = 0; i < DEPTH; i++)
                            if (occ[i] && !marked[i] && tnow >= seen[i]
                                && tnow - seen[i] > thr) begin
                                marked[i] = 1;
                                silent++;
                            end
                    add_rec(ptedb_pkg::KIND_TICK, 32'h0, 8'h0, 8'h0, 32'h0, 16'h0, acc);
                end
            endcase
            if (acc.size() > 0) acc[acc.size() - 1].last = 1;
            foreach (acc[i]) pending = {pending, acc[i]};
        endfunction

        // compare one observed result with the oldest expectation
        function void check_result(presence_rec_t got);
            presence_rec_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result kind %0d user %h", $time, got.kind,
                         got.user_key);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.kind != e.kind) report("kind", e.kind, got.kind);
            if (got.user_key != e.user_key) report("user_key", e.user_key, got.user_key);
            if (got.from_host != e.from_host) report("from_host", e.from_host, got.from_host);
            if (got.to_host != e.to_host) report("to_host", e.to_host, got.to_host);
            if (got.observed_at != e.observed_at)
                report("observed_at", e.observed_at, got.observed_at);
            if (got.sample_count != e.sample_count)
                report("sample_count", e.sample_count, got.sample_count);
            if (got.silent_total != e.silent_total)
                report("silent_total", e.silent_total, got.silent_total);
            if (got.last != e.last) report("last", e.last, got.last);
        endfunction

        function void report(string fld, logic [31:0] e, logic [31:0] a);
            $display("%0t: %s mismatch: expected %h, actual %h", $time, fld, e, a);
            errors++;
        endfunction
    endclass

    logic        clk, rst_n, start, busy, cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic [1:0]  cmd;
    logic [31:0] user_id, first_seen, frame_time, now;
    logic [7:0]  host_id;
    logic [15:0] samples;
    logic        valid, last;
    logic [2:0]  kind;
    logic [31:0] user_key, observed_at, silent_total;
    logic [7:0]  from_host, to_host;
    logic [15:0] sample_count;

    presence_board board;
    int          cycles;
    logic [31:0] clock_now;
    logic [31:0] known_users[$];
    logic [7:0]  known_hosts[$];

    presence_tracker_exit_debounce_core dut (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // result monitor and run limit
    always @(posedge clk)
    begin
        presence_rec_t r;
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("tb_presence_tracker_exit_debounce_core: done, errors");
            $finish;
        end
        if (rst_n && valid)
        begin
            r.kind = kind; r.user_key = user_key; r.from_host = from_host;
            r.to_host = to_host; r.observed_at = observed_at;
            r.sample_count = sample_count; r.silent_total = silent_total; r.last = last;
            board.check_result(r);
        end
    end

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) n = 0;
        repeat (n) @(posedge clk);
    endtask

    // drive one item and wait for its acceptance
    task automatic send_item(logic [1:0] c, logic [31:0] u, logic [7:0] h,
                             logic [15:0] smp, logic [31:0] fs, logic [31:0] ft,
                             logic [31:0] tnow);
        start <= 1; cmd <= c; user_id <= u; host_id <= h; samples <= smp;
        first_seen <= fs; frame_time <= ft; now <= tnow;
        do @(posedge clk); while (busy);
        board.note_item(c, u, h, smp, fs, ft, tnow);
        start <= 0;
        // block is busy here anyway, so this edge costs no throughput
        @(posedge clk);
        idle_gap();
    endtask

    // wait until every expected result arrived, plus the tail of the item
    task automatic drain();
        while (board.pending.size() != 0) @(posedge clk);
        repeat (25) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] v);
        cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
        @(posedge clk);
        cfg_we <= 0;
        board.set_reg(idx, v);
        @(posedge clk);
    endtask

    // random item, mostly on known users with time moving forward
    task automatic random_item();
        logic [1:0]  c;
        logic [31:0] u;
        logic [7:0]  h;
        int          k;
        c = 2'($urandom_range(0, 3));
        if (known_users.size() > 0 && $urandom_range(0, 4) != 0)
        begin
            k = $urandom_range(0, known_users.size() - 1);
            u = known_users[k];
            h = ($urandom_range(0, 3) == 0) ? 8'($urandom) : known_hosts[k];
        end
        else
        begin
            u = $urandom; h = 8'($urandom);
            if (c == ptedb_pkg::CMD_ENTRY && known_users.size() < 24)
            begin
                known_users = {known_users, u};
                known_hosts = {known_hosts, h};
            end
        end
        if ($urandom_range(0, 15) == 0) clock_now = $urandom;
        else clock_now = clock_now + $urandom_range(0, 3000);
        send_item(c, u, h, 16'($urandom), $urandom,
                  ($urandom_range(0, 1) ? clock_now - $urandom_range(0, 500) : $urandom),
                  clock_now);
    endtask

    initial
    begin
        board = new();
        board.clear();
        cycles = 0;
        rst_n = 0; start = 0; cfg_we = 0; cfg_index = ptedb_pkg::CFG_EXIT_WINDOW;
        cfg_data = 0;
        cmd = ptedb_pkg::CMD_TICK; user_id = 0; host_id = 0; samples = 0;
        first_seen = 0; frame_time = 0; now = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: entries, handover, duplicate, hold cancel, stale exit, expiry
        send_item(ptedb_pkg::CMD_ENTRY, 32'h0, 8'h00, 16'h0, 32'h0, 0, 100);
        send_item(ptedb_pkg::CMD_ENTRY, 32'hffff_ffff, 8'hff, 16'hffff, 32'hffff_ffff, 0, 100);
        send_item(ptedb_pkg::CMD_ENTRY, 32'hffff_ffff, 8'h01, 16'h1234, 32'h55, 0, 200);
        send_item(ptedb_pkg::CMD_ENTRY, 32'hffff_ffff, 8'h01, 16'h1, 32'h1, 0, 210);
        send_item(ptedb_pkg::CMD_EXIT, 32'hffff_ffff, 8'h02, 16'h7, 32'h9, 0, 220);
        send_item(ptedb_pkg::CMD_EXIT, 32'hffff_ffff, 8'h01, 16'h7, 32'h9, 0, 230);
        send_item(ptedb_pkg::CMD_ENTRY, 32'hffff_ffff, 8'h01, 16'h3, 32'h4, 0, 240);
        send_item(ptedb_pkg::CMD_EXIT, 32'h1234_5678, 8'h01, 16'h7, 32'h9, 0, 250);
        send_item(ptedb_pkg::CMD_REFRESH, 32'h1234_5678, 8'h01, 16'h0, 0, 32'hffff_ffff, 260);
        send_item(ptedb_pkg::CMD_REFRESH, 32'h0, 8'h00, 16'h0, 0, 32'd50, 260);
        send_item(ptedb_pkg::CMD_REFRESH, 32'h0, 8'h00, 16'h0, 0, 32'hf000_0000, 270);
        send_item(ptedb_pkg::CMD_TICK, 32'h0, 8'h0, 16'h0, 0, 0, 32'h8000_0000);
        send_item(ptedb_pkg::CMD_EXIT, 32'hffff_ffff, 8'h01, 16'haaaa, 32'h5555_aaaa, 0, 300);
        send_item(ptedb_pkg::CMD_TICK, 32'h0, 8'h0, 16'h0, 0, 0, 10300);
        // fill the table, then one more entry hits the full case
        for (int i = 0; i < 16; i++)
            send_item(ptedb_pkg::CMD_ENTRY, 32'h100 + i, 8'h10, 16'h0, 32'h0, 0, 20000);
        drain();

        // saturating deadline, zero-length hold, disabled telemetry, tiny threshold
        write_reg(ptedb_pkg::CFG_EXIT_WINDOW, 32'hffff_ffff);
        write_reg(ptedb_pkg::CFG_SILENCE_THR, 32'h0);
        write_reg(ptedb_pkg::CFG_TELEM_EN, 32'h0);
        send_item(ptedb_pkg::CMD_EXIT, 32'h0, 8'h00, 16'h1, 32'h2, 0, 32'hffff_0000);
        send_item(ptedb_pkg::CMD_TICK, 32'h0, 8'h0, 16'h0, 0, 0, 32'hffff_fff0);
        send_item(ptedb_pkg::CMD_TICK, 32'h0, 8'h0, 16'h0, 0, 0, 32'hffff_ffff);
        drain();
        write_reg(ptedb_pkg::CFG_EXIT_WINDOW, 32'h0);
        write_reg(ptedb_pkg::CFG_TELEM_EN, 32'h1);
        send_item(ptedb_pkg::CMD_TICK, 32'h0, 8'h0, 16'h0, 0, 0, 32'h7000_0000);
        send_item(ptedb_pkg::CMD_EXIT, 32'h100, 8'h10, 16'h2, 32'h3, 0, 32'h7000_0000);
        send_item(ptedb_pkg::CMD_TICK, 32'h0, 8'h0, 16'h0, 0, 0, 32'h7000_0000);
        drain();

        // random phases under several settings
        clock_now = 32'h7000_1000;
        for (int p = 0; p < 4; p++)
        begin
            write_reg(ptedb_pkg::CFG_EXIT_WINDOW,
                      (p == 0) ? 32'd1 : $urandom_range(1, 8000));
            write_reg(ptedb_pkg::CFG_SILENCE_THR,
                      (p == 3) ? 32'hffff_ffff : $urandom_range(0, 6000));
            write_reg(ptedb_pkg::CFG_TELEM_EN, 32'(p != 2));
            for (int i = 0; i < 16; i++) random_item();
            drain();
        end

        if (board.errors == 0 && board.pending.size() == 0)
            $display("tb_presence_tracker_exit_debounce_core: done, clean");
        else
            $display("tb_presence_tracker_exit_debounce_core: done, errors");
        $finish;
    end
endmodule
